### hw/rtl/chic_pkg.sv
// Shared types, constants and the arctangent table for the compass heading block.
package chic_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int HEAD_W   = 16;

    // Heading window and CORDIC depth
    localparam int WINDOW_LEN   = 5;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;

    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int TBL_W  = $clog2(TABLE_LEN);

    // CORDIC vector width: 16-bit sample, x256 pre-scale, gain and sign headroom
    localparam int CW  = 27;
    // Angle accumulator, units of 1/25600 degree
    localparam int Z_W = 25;

    localparam logic signed [Z_W-1:0] DEG180     = 25'sd4608000;
    localparam logic signed [Z_W-1:0] DEG360     = 25'sd9216000;
    localparam logic signed [Z_W-1:0] ROUND_HALF = 25'sd128;
    localparam int                    Z_FRAC     = 8;
    localparam logic [HEAD_W-1:0]     HEAD_MOD   = 16'd36000;

    localparam logic signed [SAMPLE_W-1:0] PEAK_RST  = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] FLOOR_RST = 16'sh7FFF;

    // Window sum and reciprocal divide by WINDOW_LEN
    localparam int SUM_W   = $clog2(WINDOW_LEN * 36000 + 1);
    localparam int DIV_SH  = SUM_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W = DIV_SH + 1;
    localparam longint RECIP_VAL = ((64'd1 << DIV_SH) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam int PROD_W  = SUM_W + RECIP_W;

    // atan(2^-i) in accumulator units, rounded
    localparam logic signed [Z_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
        25'sd1152000, 25'sd680065, 25'sd359328, 25'sd182400,
        25'sd91554,   25'sd45822,  25'sd22916,  25'sd11459,
        25'sd5730,    25'sd2865,   25'sd1432,   25'sd716,
        25'sd358,     25'sd179,    25'sd90,     25'sd45,
        25'sd22,      25'sd11,     25'sd6,      25'sd3,
        25'sd1,       25'sd1,      25'sd0,      25'sd0
    };

    typedef enum logic [1:0] {
        ACT_MEASURE     = 2'd0,
        ACT_CAL_START   = 2'd1,
        ACT_CAL_COLLECT = 2'd2,
        ACT_CAL_END     = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORR,
        ST_PRE,
        ST_ITER,
        ST_FIX,
        ST_RND,
        ST_SUM,
        ST_DIV,
        ST_MEAN,
        ST_CAL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic corr;
        logic pre;
        logic iter;
        logic fix;
        logic rnd;
        logic sum;
        logic div;
        logic mean;
        logic cal;
        logic emit;
    } cmd_t;

    typedef struct packed {
        action_t in_action;
        logic    in_good;
        logic    cordic_last;
        logic    sum_last;
    } status_t;

endpackage

### hw/rtl/chic_ctrl.sv
// Sequencer for the compass heading block: input/output handshake and datapath commands.
module chic_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  chic_pkg::status_t st,
    output chic_pkg::cmd_t    cmd
);

    chic_pkg::state_t state_reg;
    chic_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            chic_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (st.in_action == chic_pkg::ACT_MEASURE)
                    begin
                        state_next = st.in_good ? chic_pkg::ST_CORR : chic_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = chic_pkg::ST_CAL;
                    end
                end
            end
            chic_pkg::ST_CORR: state_next = chic_pkg::ST_PRE;
            chic_pkg::ST_PRE:  state_next = chic_pkg::ST_ITER;
            chic_pkg::ST_ITER:
            begin
                if (st.cordic_last)
                begin
                    state_next = chic_pkg::ST_FIX;
                end
            end
            chic_pkg::ST_FIX:  state_next = chic_pkg::ST_RND;
            chic_pkg::ST_RND:  state_next = chic_pkg::ST_SUM;
            chic_pkg::ST_SUM:
            begin
                if (st.sum_last)
                begin
                    state_next = chic_pkg::ST_DIV;
                end
            end
            chic_pkg::ST_DIV:  state_next = chic_pkg::ST_MEAN;
            chic_pkg::ST_MEAN: state_next = chic_pkg::ST_EMIT;
            chic_pkg::ST_CAL:  state_next = chic_pkg::ST_EMIT;
            chic_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = chic_pkg::ST_IDLE;
                end
            end
            default: state_next = chic_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            chic_pkg::ST_IDLE: cmd.load = in_valid;
            chic_pkg::ST_CORR: cmd.corr = 1'b1;
            chic_pkg::ST_PRE:  cmd.pre  = 1'b1;
            chic_pkg::ST_ITER: cmd.iter = 1'b1;
            chic_pkg::ST_FIX:  cmd.fix  = 1'b1;
            chic_pkg::ST_RND:  cmd.rnd  = 1'b1;
            chic_pkg::ST_SUM:  cmd.sum  = 1'b1;
            chic_pkg::ST_DIV:  cmd.div  = 1'b1;
            chic_pkg::ST_MEAN: cmd.mean = 1'b1;
            chic_pkg::ST_CAL:  cmd.cal  = 1'b1;
            chic_pkg::ST_EMIT: cmd.emit = !out_valid_reg || !out_stall;
            default:           cmd      = '0;
        endcase
    end

    // output word stays until taken; a fresh emit may replace a taken one
    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chic_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != chic_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != chic_pkg::ST_IDLE))
        else $error("accepted word did not start processing");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.emit)
        else $error("pending output word overwritten");

    a_cordic_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chic_pkg::ST_ITER && st.cordic_last) |=> (state_reg == chic_pkg::ST_FIX))
        else $error("CORDIC did not finish after last step");
`endif

endmodule

### hw/rtl/chic_dp.sv
// Datapath: offset correction, iterative CORDIC heading, window mean and calibration.
module chic_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  chic_pkg::cmd_t                      cmd,
    output chic_pkg::status_t                   st,
    input  logic [1:0]                          action,
    input  logic signed [chic_pkg::SAMPLE_W-1:0] x_sample,
    input  logic signed [chic_pkg::SAMPLE_W-1:0] y_sample,
    input  logic                                data_ready,
    input  logic                                data_overflow,
    output logic                                sample_taken,
    output logic signed [chic_pkg::SAMPLE_W-1:0] corrected_x,
    output logic signed [chic_pkg::SAMPLE_W-1:0] corrected_y,
    output logic [chic_pkg::HEAD_W-1:0]         heading_now,
    output logic [chic_pkg::HEAD_W-1:0]         heading_smoothed,
    output logic signed [chic_pkg::SAMPLE_W-1:0] x_offset_now,
    output logic signed [chic_pkg::SAMPLE_W-1:0] y_offset_now
);

    localparam int SW = chic_pkg::SAMPLE_W;
    localparam int HW = chic_pkg::HEAD_W;
    localparam int CW = chic_pkg::CW;
    localparam int ZW = chic_pkg::Z_W;

    // latched input word
    chic_pkg::action_t    act_reg;
    logic signed [SW-1:0] xs_reg;
    logic signed [SW-1:0] ys_reg;
    logic                 taken_reg;

    // architectural state
    logic signed [SW-1:0] held_x_reg;
    logic signed [SW-1:0] held_y_reg;
    logic [HW-1:0]        heading_reg;
    logic [HW-1:0]        mean_reg;
    logic signed [SW-1:0] x_peak_reg;
    logic signed [SW-1:0] x_floor_reg;
    logic signed [SW-1:0] y_peak_reg;
    logic signed [SW-1:0] y_floor_reg;
    logic signed [SW-1:0] x_off_reg;
    logic signed [SW-1:0] y_off_reg;
    logic [HW-1:0]        window_reg [chic_pkg::WINDOW_LEN];
    logic [chic_pkg::SLOT_W-1:0] slot_reg;

    // working registers
    logic signed [CW-1:0] cx_reg;
    logic signed [CW-1:0] cy_reg;
    logic signed [ZW-1:0] z_reg;
    logic                 zero_reg;
    logic [chic_pkg::TBL_W-1:0]  step_reg;
    logic [chic_pkg::SLOT_W-1:0] sidx_reg;
    logic [chic_pkg::SUM_W-1:0]  sum_reg;
    logic [chic_pkg::PROD_W-1:0] prod_reg;

    // output word
    logic                 o_taken_reg;
    logic signed [SW-1:0] o_x_reg;
    logic signed [SW-1:0] o_y_reg;
    logic [HW-1:0]        o_head_reg;
    logic [HW-1:0]        o_mean_reg;
    logic signed [SW-1:0] o_xoff_reg;
    logic signed [SW-1:0] o_yoff_reg;

    chic_pkg::action_t    in_act;
    logic                 in_good;
    logic signed [CW-1:0] ext_x;
    logic signed [CW-1:0] ext_y;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] atan_step;
    logic signed [ZW-1:0] z_round;
    logic [HW-1:0]        head_raw;
    logic [HW-1:0]        head_fin;
    logic signed [SW:0]   x_mid_sum;
    logic signed [SW:0]   y_mid_sum;
    logic signed [SW:0]   x_mid_adj;
    logic signed [SW:0]   y_mid_adj;

    assign in_act  = chic_pkg::action_t'(action);
    assign in_good = data_ready && !data_overflow;

    assign st.in_action   = in_act;
    assign st.in_good     = in_good;
    assign st.cordic_last = (step_reg == chic_pkg::TBL_W'(chic_pkg::CORDIC_STEPS - 1));
    assign st.sum_last    = (sidx_reg == chic_pkg::SLOT_W'(chic_pkg::WINDOW_LEN - 1));

    // pre-scale by 256
    assign ext_x = {{(CW-SW-8){held_x_reg[SW-1]}}, held_x_reg, 8'h00};
    assign ext_y = {{(CW-SW-8){held_y_reg[SW-1]}}, held_y_reg, 8'h00};

    assign dx        = cy_reg >>> step_reg;
    assign dy        = cx_reg >>> step_reg;
    assign atan_step = chic_pkg::ATAN_TABLE[step_reg];

    // z is non-negative here; round half up to hundredths, 36000 folds to 0
    assign z_round  = z_reg + chic_pkg::ROUND_HALF;
    assign head_raw = z_round[chic_pkg::Z_FRAC +: HW];
    assign head_fin = zero_reg ? '0 :
                      (head_raw >= chic_pkg::HEAD_MOD) ? head_raw - chic_pkg::HEAD_MOD : head_raw;

    // (max+min)/2 toward zero: add one when negative, then drop the low bit
    assign x_mid_sum = {x_peak_reg[SW-1], x_peak_reg} + {x_floor_reg[SW-1], x_floor_reg};
    assign y_mid_sum = {y_peak_reg[SW-1], y_peak_reg} + {y_floor_reg[SW-1], y_floor_reg};
    assign x_mid_adj = x_mid_sum + {{SW{1'b0}}, x_mid_sum[SW]};
    assign y_mid_adj = y_mid_sum + {{SW{1'b0}}, y_mid_sum[SW]};

    // state with defined reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg  <= '0;
            held_y_reg  <= '0;
            heading_reg <= '0;
            mean_reg    <= '0;
            x_peak_reg  <= chic_pkg::PEAK_RST;
            x_floor_reg <= chic_pkg::FLOOR_RST;
            y_peak_reg  <= chic_pkg::PEAK_RST;
            y_floor_reg <= chic_pkg::FLOOR_RST;
            x_off_reg   <= '0;
            y_off_reg   <= '0;
            slot_reg    <= '0;
            for (int i = 0; i < chic_pkg::WINDOW_LEN; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.corr)
            begin
                held_x_reg <= xs_reg - x_off_reg;
                held_y_reg <= ys_reg - y_off_reg;
            end
            if (cmd.rnd)
            begin
                heading_reg          <= head_fin;
                window_reg[slot_reg] <= head_fin;
                if (slot_reg == chic_pkg::SLOT_W'(chic_pkg::WINDOW_LEN - 1))
                begin
                    slot_reg <= '0;
                end
                else
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
            if (cmd.mean)
            begin
                mean_reg <= HW'(prod_reg >> chic_pkg::DIV_SH);
            end
            if (cmd.cal)
            begin
                case (act_reg)
                    chic_pkg::ACT_CAL_START:
                    begin
                        x_peak_reg  <= chic_pkg::PEAK_RST;
                        x_floor_reg <= chic_pkg::FLOOR_RST;
                        y_peak_reg  <= chic_pkg::PEAK_RST;
                        y_floor_reg <= chic_pkg::FLOOR_RST;
                    end
                    chic_pkg::ACT_CAL_COLLECT:
                    begin
                        if (taken_reg)
                        begin
                            if (xs_reg > x_peak_reg)  x_peak_reg  <= xs_reg;
                            if (xs_reg < x_floor_reg) x_floor_reg <= xs_reg;
                            if (ys_reg > y_peak_reg)  y_peak_reg  <= ys_reg;
                            if (ys_reg < y_floor_reg) y_floor_reg <= ys_reg;
                        end
                    end
                    chic_pkg::ACT_CAL_END:
                    begin
                        x_off_reg <= x_mid_adj[SW:1];
                        y_off_reg <= y_mid_adj[SW:1];
                    end
                    default:
                    begin
                        x_off_reg <= x_off_reg;
                    end
                endcase
            end
        end
    end

    // scratch and output word, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= in_act;
            xs_reg    <= x_sample;
            ys_reg    <= y_sample;
            taken_reg <= in_good && (in_act == chic_pkg::ACT_MEASURE ||
                                     in_act == chic_pkg::ACT_CAL_COLLECT);
        end
        if (cmd.pre)
        begin
            zero_reg <= (held_x_reg == '0) && (held_y_reg == '0);
            step_reg <= '0;
            if (held_x_reg[SW-1])
            begin
                cx_reg <= -ext_x;
                cy_reg <= -ext_y;
                z_reg  <= chic_pkg::DEG180;
            end
            else
            begin
                cx_reg <= ext_x;
                cy_reg <= ext_y;
                z_reg  <= '0;
            end
        end
        if (cmd.iter)
        begin
            step_reg <= step_reg + 1'b1;
            if (!cy_reg[CW-1])
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                z_reg  <= z_reg + atan_step;
            end
            else
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                z_reg  <= z_reg - atan_step;
            end
        end
        if (cmd.fix)
        begin
            if (z_reg[ZW-1])
            begin
                z_reg <= z_reg + chic_pkg::DEG360;
            end
        end
        if (cmd.rnd)
        begin
            sum_reg  <= '0;
            sidx_reg <= '0;
        end
        if (cmd.sum)
        begin
            sum_reg  <= sum_reg + chic_pkg::SUM_W'(window_reg[sidx_reg]);
            sidx_reg <= sidx_reg + 1'b1;
        end
        if (cmd.div)
        begin
            prod_reg <= chic_pkg::PROD_W'(sum_reg) * chic_pkg::PROD_W'(chic_pkg::RECIP);
        end
        if (cmd.emit)
        begin
            o_taken_reg <= taken_reg;
            o_x_reg     <= held_x_reg;
            o_y_reg     <= held_y_reg;
            o_head_reg  <= heading_reg;
            o_mean_reg  <= mean_reg;
            o_xoff_reg  <= x_off_reg;
            o_yoff_reg  <= y_off_reg;
        end
    end

    assign sample_taken     = o_taken_reg;
    assign corrected_x      = o_x_reg;
    assign corrected_y      = o_y_reg;
    assign heading_now      = o_head_reg;
    assign heading_smoothed = o_mean_reg;
    assign x_offset_now     = o_xoff_reg;
    assign y_offset_now     = o_yoff_reg;

`ifndef NO_ASSERTIONS
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        heading_reg < chic_pkg::HEAD_MOD)
        else $error("heading out of range");

    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        mean_reg < chic_pkg::HEAD_MOD)
        else $error("window mean out of range");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, slot_reg} < (chic_pkg::SLOT_W + 1)'(chic_pkg::WINDOW_LEN))
        else $error("window slot beyond window length");
`endif

endmodule

### hw/rtl/compass_heading_with_hard_iron_cal.sv
// Top level: compass heading with hard-iron calibration, sequencer plus datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_stall  | action, x_sample, y_sample, data_ready,
//          |                      | data_overflow
//  out     | out_valid / out_stall| sample_taken, corrected_x, corrected_y,
//          |                      | heading_now, heading_smoothed, x_offset_now,
//          |                      | y_offset_now
//
// One output word per input word, in order.
// A good measure word is worked on from accept to the next accept with one CORDIC
// micro-rotation a cycle, then one window entry a cycle into the mean sum, then
// a reciprocal multiply for the divide by WINDOW_LEN.
// in_stall is high while a word is being worked on; the next word is taken while the
// previous result still sits unclaimed in the output register.
// A full output register under out_stall holds the sequencer before it emits.
// rst_n is asynchronous: window cleared, extrema to their sentinels, offsets to zero.
module compass_heading_with_hard_iron_cal
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          action,
    input  logic signed [chic_pkg::SAMPLE_W-1:0] x_sample,
    input  logic signed [chic_pkg::SAMPLE_W-1:0] y_sample,
    input  logic                                data_ready,
    input  logic                                data_overflow,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                sample_taken,
    output logic signed [chic_pkg::SAMPLE_W-1:0] corrected_x,
    output logic signed [chic_pkg::SAMPLE_W-1:0] corrected_y,
    output logic [chic_pkg::HEAD_W-1:0]         heading_now,
    output logic [chic_pkg::HEAD_W-1:0]         heading_smoothed,
    output logic signed [chic_pkg::SAMPLE_W-1:0] x_offset_now,
    output logic signed [chic_pkg::SAMPLE_W-1:0] y_offset_now
);

    // commands down, status up; nothing else crosses between the two halves
    chic_pkg::cmd_t    cmd;
    chic_pkg::status_t st;

    chic_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // offset subtract, CORDIC, window mean, extrema tracking and the output word
    chic_dp u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .action           (action),
        .x_sample         (x_sample),
        .y_sample         (y_sample),
        .data_ready       (data_ready),
        .data_overflow    (data_overflow),
        .sample_taken     (sample_taken),
        .corrected_x      (corrected_x),
        .corrected_y      (corrected_y),
        .heading_now      (heading_now),
        .heading_smoothed (heading_smoothed),
        .x_offset_now     (x_offset_now),
        .y_offset_now     (y_offset_now)
    );

endmodule
